// File: design/hblm_pkg.sv
// Shared types, codes and helpers for the heartbeat liveness monitor.
// Depends on nothing; every other design file imports it.
`timescale 1ns / 1ps

package hblm_pkg;

   // Peer table geometry
   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   // Field widths
   localparam int KEY_W  = 32;
   localparam int TIME_W = 24;
   localparam int ELAP_W = 16;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Item function codes
   localparam logic [1:0] FN_TICK      = 2'd0;
   localparam logic [1:0] FN_HEARTBEAT = 2'd1;
   localparam logic [1:0] FN_REGISTER  = 2'd2;

   // Event kinds
   localparam logic [1:0] EV_SEND    = 2'd0;
   localparam logic [1:0] EV_STOP    = 2'd1;
   localparam logic [1:0] EV_RESTART = 2'd2;
   localparam logic [1:0] EV_FULL    = 2'd3;

   // Register indexes
   localparam logic [2:0] REG_OWN_KEY        = 3'd0;
   localparam logic [2:0] REG_SEND_ENABLE    = 3'd1;
   localparam logic [2:0] REG_RECEIVE_ENABLE = 3'd2;
   localparam logic [2:0] REG_SEND_INTERVAL  = 3'd3;
   localparam logic [2:0] REG_DEFAULT_LIMIT  = 3'd4;

   localparam logic [TIME_W-1:0] SEND_INTERVAL_RST = TIME_W'(1000);
   localparam logic [TIME_W-1:0] DEFAULT_LIMIT_RST = TIME_W'(5000);

   typedef struct packed {
      logic [1:0]        func;
      logic [KEY_W-1:0]  peer_key;
      logic [ELAP_W-1:0] elapsed_ms;
      logic [TIME_W-1:0] age_limit;
   } req_item_type;

   typedef struct packed {
      logic [1:0]       event_kind;
      logic [KEY_W-1:0] event_key;
      logic             last;
   } rsp_item_type;

   typedef struct packed {
      logic [KEY_W-1:0]  own_key;
      logic              send_enable;
      logic              receive_enable;
      logic [TIME_W-1:0] send_interval;
      logic [TIME_W-1:0] default_limit;
   } cfg_type;

   typedef struct packed {
      logic              reported;
      logic [TIME_W-1:0] limit;
      logic [TIME_W-1:0] age;
      logic [KEY_W-1:0]  key;
   } peer_entry_type;

   // Event from the sequencer to the result stage
   typedef struct packed {
      logic             valid;
      logic             finish;
      logic [1:0]       kind;
      logic [KEY_W-1:0] key;
   } event_type;

   // Add elapsed milliseconds to an age, saturating at the top of the range
   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [ELAP_W-1:0] b);
      logic [TIME_W:0] sum;
      sum = {1'b0, a} + {{(TIME_W + 1 - ELAP_W){1'b0}}, b};
      return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
   endfunction

endpackage

// File: design/hblm_csr.sv
// Configuration registers behind the APB-style port.
// Depends on hblm_pkg for register indexes, reset values and cfg_type.
`timescale 1ns / 1ps

module hblm_csr import hblm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   // Decode the write transaction
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_OWN_KEY:        cfg_in.own_key        = pwdata;
            REG_SEND_ENABLE:    cfg_in.send_enable    = pwdata[0];
            REG_RECEIVE_ENABLE: cfg_in.receive_enable = pwdata[0];
            REG_SEND_INTERVAL:  cfg_in.send_interval  = pwdata[TIME_W-1:0];
            REG_DEFAULT_LIMIT:  cfg_in.default_limit  = pwdata[TIME_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_key        <= '0;
         cfg_ff.send_enable    <= 1'b0;
         cfg_ff.receive_enable <= 1'b0;
         cfg_ff.send_interval  <= SEND_INTERVAL_RST;
         cfg_ff.default_limit  <= DEFAULT_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Return the addressed register
   always_comb begin
      unique case (reg_idx)
         REG_OWN_KEY:        prdata = cfg_ff.own_key;
         REG_SEND_ENABLE:    prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.send_enable};
         REG_RECEIVE_ENABLE: prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.receive_enable};
         REG_SEND_INTERVAL:  prdata = {{(CSR_DATA_W-TIME_W){1'b0}}, cfg_ff.send_interval};
         REG_DEFAULT_LIMIT:  prdata = {{(CSR_DATA_W-TIME_W){1'b0}}, cfg_ff.default_limit};
         default:            prdata = '0;
      endcase
   end

endmodule

// File: design/hblm_mem.sv
// Peer table memory: one write port, one read port, registered read data.
// Depends on hblm_pkg for the entry type and table depth.
`timescale 1ns / 1ps

module hblm_mem import hblm_pkg::*; (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output peer_entry_type   rd_data,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  peer_entry_type   wr_data
);

   peer_entry_type entry_mem [ENTRIES];
   peer_entry_type rd_data_ff;

   assign rd_data = rd_data_ff;

   // Write the entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   // Read the entry into the registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

endmodule

// File: design/hblm_ctrl.sv
// Sequencer: decodes an item and walks the peer table with read-modify-write.
// Depends on hblm_pkg; drives hblm_mem and feeds events to hblm_rsp.
`timescale 1ns / 1ps

module hblm_ctrl import hblm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_item_type     req_item,
   input  cfg_type          cfg,
   output logic             mem_rd_en,
   output logic [IDX_W-1:0] mem_rd_addr,
   input  peer_entry_type   mem_rd_data,
   output logic             mem_wr_en,
   output logic [IDX_W-1:0] mem_wr_addr,
   output peer_entry_type   mem_wr_data,
   output event_type        evt
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_START  = 7'b0000010,
      ST_AGE    = 7'b0000100,
      ST_CHECK  = 7'b0001000,
      ST_FIND   = 7'b0010000,
      ST_APPEND = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type         state_ff,    state_in;
   req_item_type      item_ff,     item_in;
   logic [TIME_W-1:0] send_age_ff, send_age_in;
   logic [CNT_W-1:0]  count_ff,    count_in;
   logic [CNT_W-1:0]  ptr_ff,      ptr_in;
   logic              rvalid_ff,   rvalid_in;
   logic [IDX_W-1:0]  raddr_ff,    raddr_in;

   logic              issue;
   logic [TIME_W-1:0] aged;
   logic [TIME_W-1:0] send_sum;
   logic [TIME_W-1:0] new_limit;

   assign busy      = (state_ff != ST_IDLE);
   assign issue     = (ptr_ff != count_ff);
   assign aged      = sat_add(mem_rd_data.age, item_ff.elapsed_ms);
   assign send_sum  = sat_add(send_age_ff, item_ff.elapsed_ms);
   assign new_limit = (item_ff.func == FN_REGISTER) ? item_ff.age_limit : cfg.default_limit;

   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      send_age_in = send_age_ff;
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      rvalid_in   = 1'b0;
      raddr_in    = raddr_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = ptr_ff[IDX_W-1:0];
      mem_wr_en   = 1'b0;
      mem_wr_addr = raddr_ff;
      mem_wr_data = mem_rd_data;
      evt         = '0;

      unique case (state_ff)
         // Take the transaction
         ST_IDLE: begin
            item_in = req_item;
            if (start) begin
               state_in = ST_START;
            end
         end

         // Route the item; advance the send timer on a tick while sending is enabled
         ST_START: begin
            ptr_in = '0;
            case (item_ff.func)
               FN_TICK: begin
                  if (cfg.send_enable) begin
                     if (send_sum > cfg.send_interval) begin
                        evt.valid   = 1'b1;
                        evt.kind    = EV_SEND;
                        evt.key     = '0;
                        send_age_in = '0;
                     end else begin
                        send_age_in = send_sum;
                     end
                  end
                  state_in = cfg.receive_enable ? ST_AGE : ST_DONE;
               end
               FN_HEARTBEAT: begin
                  if (cfg.receive_enable && (item_ff.peer_key != cfg.own_key)) begin
                     state_in = ST_FIND;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               FN_REGISTER: state_in = ST_APPEND;
               default:     state_in = ST_DONE;
            endcase
         end

         // Age each peer and report the ones that passed their limit and are not yet reported
         ST_AGE: begin
            if (issue) begin
               mem_rd_en = 1'b1;
               ptr_in    = ptr_ff + 1'b1;
               rvalid_in = 1'b1;
               raddr_in  = ptr_ff[IDX_W-1:0];
            end
            if (rvalid_ff) begin
               mem_wr_en       = 1'b1;
               mem_wr_data.age = aged;
               if ((aged > mem_rd_data.limit) && !mem_rd_data.reported) begin
                  evt.valid            = 1'b1;
                  evt.kind             = EV_STOP;
                  evt.key              = mem_rd_data.key;
                  mem_wr_data.reported = 1'b1;
               end
            end
            if (!issue && !rvalid_ff) begin
               ptr_in   = '0;
               state_in = ST_CHECK;
            end
         end

         // Report reported peers that are back under their limit
         ST_CHECK: begin
            if (issue) begin
               mem_rd_en = 1'b1;
               ptr_in    = ptr_ff + 1'b1;
               rvalid_in = 1'b1;
               raddr_in  = ptr_ff[IDX_W-1:0];
            end
            if (rvalid_ff && mem_rd_data.reported &&
                (mem_rd_data.age < mem_rd_data.limit)) begin
               evt.valid            = 1'b1;
               evt.kind             = EV_RESTART;
               evt.key              = mem_rd_data.key;
               mem_wr_en            = 1'b1;
               mem_wr_data.reported = 1'b0;
            end
            if (!issue && !rvalid_ff) begin
               state_in = ST_DONE;
            end
         end

         // Search for the first matching key; clear its age on a hit, append on a miss
         ST_FIND: begin
            if (issue) begin
               mem_rd_en = 1'b1;
               ptr_in    = ptr_ff + 1'b1;
               rvalid_in = 1'b1;
               raddr_in  = ptr_ff[IDX_W-1:0];
            end
            if (rvalid_ff && (mem_rd_data.key == item_ff.peer_key)) begin
               mem_wr_en       = 1'b1;
               mem_wr_data.age = '0;
               state_in        = ST_DONE;
            end else if (!issue && !rvalid_ff) begin
               state_in = ST_APPEND;
            end
         end

         // Add a peer at the end of the table, or flag a full table
         ST_APPEND: begin
            if (count_ff == CNT_W'(ENTRIES)) begin
               evt.valid = 1'b1;
               evt.kind  = EV_FULL;
               evt.key   = item_ff.peer_key;
            end else begin
               mem_wr_en            = 1'b1;
               mem_wr_addr          = count_ff[IDX_W-1:0];
               mem_wr_data.reported = 1'b0;
               mem_wr_data.limit    = new_limit;
               mem_wr_data.age      = '0;
               mem_wr_data.key      = item_ff.peer_key;
               count_in             = count_ff + 1'b1;
            end
            state_in = ST_DONE;
         end

         // Close the item so the last result gets marked
         ST_DONE: begin
            evt.finish = 1'b1;
            state_in   = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         send_age_ff <= '0;
         count_ff    <= '0;
         ptr_ff      <= '0;
         rvalid_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         send_age_ff <= send_age_in;
         count_ff    <= count_in;
         ptr_ff      <= ptr_in;
         rvalid_ff   <= rvalid_in;
      end
   end

   // Hold the payload
   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      raddr_ff <= raddr_in;
   end

endmodule

// File: design/hblm_rsp.sv
// Result stage: keeps one event back so the final one can carry last.
// Depends on hblm_pkg for event_type and rsp_item_type.
`timescale 1ns / 1ps

module hblm_rsp import hblm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  event_type    evt,
   output logic         rsp_valid,
   output rsp_item_type rsp_item
);

   logic         pend_valid_ff, pend_valid_in;
   event_type    pend_ff,       pend_in;
   logic         rsp_valid_ff,  rsp_valid_in;
   rsp_item_type rsp_item_ff,   rsp_item_in;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Release the held event when a newer one arrives or the item ends
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = 1'b0;
      rsp_item_in   = rsp_item_ff;
      if (evt.valid) begin
         if (pend_valid_ff) begin
            rsp_valid_in         = 1'b1;
            rsp_item_in.event_kind = pend_ff.kind;
            rsp_item_in.event_key  = pend_ff.key;
            rsp_item_in.last       = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_in       = evt;
      end else if (evt.finish) begin
         if (pend_valid_ff) begin
            rsp_valid_in           = 1'b1;
            rsp_item_in.event_kind = pend_ff.kind;
            rsp_item_in.event_key  = pend_ff.key;
            rsp_item_in.last       = 1'b1;
         end
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      rsp_item_ff <= rsp_item_in;
   end

endmodule

// File: design/heartbeat_liveness_monitor_top.sv
// Heartbeat liveness monitor, one item at a time; results cannot be stalled.
// A tick holds busy while the peer table memory is walked twice through its single read port
// (aging, then restart); with receiving off it skips both walks.
// A heartbeat runs a key search, then an append on a miss; a register goes straight to append.
// Each result leaves in the cycle after the next event or the end of its item.
// Synchronous reset clears peer count, send timer and registers; the table is not cleared.
`timescale 1ns / 1ps

module heartbeat_liveness_monitor_top import hblm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_item_type          req_item,
   output logic                  rsp_valid,
   output rsp_item_type          rsp_item,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type          cfg;
   event_type        evt;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_rd_addr;
   peer_entry_type   mem_rd_data;
   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   peer_entry_type   mem_wr_data;

   hblm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   hblm_mem u_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   hblm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .cfg         (cfg),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .evt         (evt)
   );

   hblm_rsp u_rsp (
      .clock     (clock),
      .reset     (reset),
      .evt       (evt),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

`ifndef SYNTHESIS
   // An accepted transaction keeps the block busy
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("busy not raised after accepted transaction");

   // Send events carry a zero key
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && (rsp_item.event_kind == EV_SEND)) |->
                    (rsp_item.event_key == '0))
      else $error("send event with nonzero key");

   // The final result of an item is never followed at once by another
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && rsp_item.last) |=> !rsp_valid)
      else $error("result directly after final result");

   // No result is emitted while the block idled through the previous cycle
   assert property (@(posedge clock) disable iff (reset)
                    (!busy && !$past(busy) && !$past(reset)) |-> !rsp_valid)
      else $error("result without an item in progress");
`endif

endmodule
